// ===== hdl/voxel_face_cull_ao_defines.svh =====
// Assertion helpers used by the top-level file to check block behavior.
`ifndef VOXEL_FACE_CULL_AO_DEFINES_SVH
`define VOXEL_FACE_CULL_AO_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define VFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define VFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/vfc_pkg.sv =====
package vfc_pkg;

  localparam int TILE_INDEX_BITS_DEF = 12;
  localparam int NBR_BITS = 27;
  localparam int NUM_FACES = 6;
  localparam int NUM_TILE_SEL = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam int SEL_SIDE = 0;
  localparam int SEL_TOP = 1;
  localparam int SEL_BOTTOM = 2;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SOLID = 2'd1,
    KIND_WATER = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_t;

  typedef struct packed {
    logic [NBR_BITS-1:0]  occ;
    logic [NUM_FACES-1:0] vis;
    logic                 is_water;
  } vfc_ctl_t;

  localparam int NORMAL_TAB [NUM_FACES][3] = '{
    '{1, 0, 0}, '{-1, 0, 0}, '{0, 1, 0}, '{0, -1, 0}, '{0, 0, 1}, '{0, 0, -1}
  };
  localparam int AX_TAB [NUM_FACES][3] = '{
    '{0, 0, 1}, '{0, 0, -1}, '{-1, 0, 0}, '{-1, 0, 0}, '{1, 0, 0}, '{-1, 0, 0}
  };
  localparam int AY_TAB [NUM_FACES][3] = '{
    '{0, 1, 0}, '{0, 1, 0}, '{0, 0, -1}, '{0, 0, 1}, '{0, 1, 0}, '{0, 1, 0}
  };

  function automatic logic [4:0] nbr_bit(input int dx, input int dy, input int dz);
    return 5'((dx + 1) * 9 + (dy + 1) * 3 + (dz + 1));
  endfunction

  function automatic logic [4:0] normal_bit(input int f);
    return nbr_bit(NORMAL_TAB[f][0], NORMAL_TAB[f][1], NORMAL_TAB[f][2]);
  endfunction

  function automatic logic [1:0] corner_level(input logic [NBR_BITS-1:0] occ, input int f,
                                              input int sx, input int sy);
    logic s1;
    logic s2;
    logic c;
    s1 = occ[nbr_bit(AX_TAB[f][0] * sx, AX_TAB[f][1] * sx, AX_TAB[f][2] * sx)];
    s2 = occ[nbr_bit(AY_TAB[f][0] * sy, AY_TAB[f][1] * sy, AY_TAB[f][2] * sy)];
    c  = occ[nbr_bit(AX_TAB[f][0] * sx + AY_TAB[f][0] * sy,
                     AX_TAB[f][1] * sx + AY_TAB[f][1] * sy,
                     AX_TAB[f][2] * sx + AY_TAB[f][2] * sy)];
    if (s1 && s2) begin
      return 2'd3;
    end
    return {1'b0, s1} + {1'b0, s2} + {1'b0, c};
  endfunction

endpackage

// ===== hdl/vfc_if.sv =====
interface vfc_in_if #(
  parameter int TILE_INDEX_BITS = vfc_pkg::TILE_INDEX_BITS_DEF
);
  localparam int TileW = TILE_INDEX_BITS + 1;

  logic                           valid;
  logic                           ready;
  logic [1:0]                     voxel_kind;
  logic [vfc_pkg::NBR_BITS-1:0]   solid_neighbors;
  logic [vfc_pkg::NBR_BITS-1:0]   water_neighbors;
  logic                           textured;
  logic signed [TileW-1:0]        tile_all;
  logic signed [TileW-1:0]        tile_side;
  logic signed [TileW-1:0]        tile_top;
  logic signed [TileW-1:0]        tile_bottom;

  modport source (
    output valid, voxel_kind, solid_neighbors, water_neighbors, textured,
           tile_all, tile_side, tile_top, tile_bottom,
    input  ready
  );
  modport sink (
    input  valid, voxel_kind, solid_neighbors, water_neighbors, textured,
           tile_all, tile_side, tile_top, tile_bottom,
    output ready
  );
endinterface

interface vfc_out_if #(
  parameter int TILE_INDEX_BITS = vfc_pkg::TILE_INDEX_BITS_DEF
);
  localparam int TileW = TILE_INDEX_BITS + 1;

  logic                    valid;
  logic                    ready;
  logic [2:0]              face;
  logic signed [TileW-1:0] tile;
  logic [1:0]              ao_bottom_left;
  logic [1:0]              ao_bottom_right;
  logic [1:0]              ao_top_right;
  logic [1:0]              ao_top_left;
  logic                    is_water;
  logic                    last;

  modport source (
    output valid, face, tile, ao_bottom_left, ao_bottom_right, ao_top_right,
           ao_top_left, is_water, last,
    input  ready
  );
  modport sink (
    input  valid, face, tile, ao_bottom_left, ao_bottom_right, ao_top_right,
           ao_top_left, is_water, last,
    output ready
  );
endinterface

// ===== hdl/vfc_front.sv =====
module vfc_front #(
  parameter int TILE_INDEX_BITS = vfc_pkg::TILE_INDEX_BITS_DEF
) (
  vfc_in_if.sink                                        in_ch,
  output logic                                          q_wr_valid,
  input  logic                                          q_wr_ready,
  output vfc_pkg::vfc_ctl_t                             q_wr_ctl,
  output logic [vfc_pkg::NUM_TILE_SEL-1:0][TILE_INDEX_BITS:0] q_wr_tiles
);
  localparam int TileW = TILE_INDEX_BITS + 1;

  logic                                    active;
  logic [vfc_pkg::NBR_BITS-1:0]            occ;
  logic [vfc_pkg::NUM_TILE_SEL-1:0][TileW-1:0] spec;

  always_comb begin
    active = 1'b0;
    occ = '0;
    case (in_ch.voxel_kind)
      vfc_pkg::KIND_SOLID: begin
        active = 1'b1;
        occ = in_ch.solid_neighbors;
      end
      vfc_pkg::KIND_WATER: begin
        active = 1'b1;
        occ = in_ch.solid_neighbors | in_ch.water_neighbors;
      end
      default: begin
        active = 1'b0;
        occ = '0;
      end
    endcase
  end

  always_comb begin
    q_wr_ctl.occ = occ;
    q_wr_ctl.is_water = (in_ch.voxel_kind == vfc_pkg::KIND_WATER);
    for (int f = 0; f < vfc_pkg::NUM_FACES; f++) begin
      q_wr_ctl.vis[f] = active && !occ[vfc_pkg::normal_bit(f)];
    end
  end

  // resolve each tile class: none if untextured, else own tile, then fallback, then none
  always_comb begin
    spec[vfc_pkg::SEL_SIDE]   = in_ch.tile_side;
    spec[vfc_pkg::SEL_TOP]    = in_ch.tile_top;
    spec[vfc_pkg::SEL_BOTTOM] = in_ch.tile_bottom;
    for (int s = 0; s < vfc_pkg::NUM_TILE_SEL; s++) begin
      if (!in_ch.textured) begin
        q_wr_tiles[s] = '1;
      end else if (!spec[s][TileW-1]) begin
        q_wr_tiles[s] = spec[s];
      end else if (!in_ch.tile_all[TileW-1]) begin
        q_wr_tiles[s] = in_ch.tile_all;
      end else begin
        q_wr_tiles[s] = '1;
      end
    end
  end

  // drop voxels with no visible face
  assign q_wr_valid  = in_ch.valid && (|q_wr_ctl.vis);
  assign in_ch.ready = q_wr_ready;

endmodule

// ===== hdl/vfc_queue.sv =====
module vfc_queue #(
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  localparam int Depth = vfc_pkg::QUEUE_DEPTH;
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [WIDTH-1:0] mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r;
  logic [PtrW-1:0]  rd_ptr_r;
  logic [CntW-1:0]  count_r;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != CntW'(Depth));
  assign rd_valid = (count_r != '0);
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/vfc_back.sv =====
module vfc_back #(
  parameter int TILE_INDEX_BITS = vfc_pkg::TILE_INDEX_BITS_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                q_rd_valid,
  output logic                                                q_rd_ready,
  input  vfc_pkg::vfc_ctl_t                                   q_rd_ctl,
  input  logic [vfc_pkg::NUM_TILE_SEL-1:0][TILE_INDEX_BITS:0] q_rd_tiles,
  vfc_out_if.source                                           out_ch
);
  localparam int TileW = TILE_INDEX_BITS + 1;

  logic                                        cur_valid_r;
  vfc_pkg::vfc_ctl_t                           cur_ctl_r;
  logic [vfc_pkg::NUM_TILE_SEL-1:0][TileW-1:0] cur_tiles_r;
  logic [vfc_pkg::NUM_FACES-1:0]               cur_vis_nxt;

  logic                                        out_valid_r;
  vfc_pkg::face_t                              out_face_r;
  logic [TileW-1:0]                            out_tile_r;
  logic [3:0][1:0]                             out_ao_r;
  logic                                        out_water_r;
  logic                                        out_last_r;

  vfc_pkg::face_t                              sel_face;
  logic [vfc_pkg::NUM_FACES-1:0]               sel_onehot;
  logic                                        found;
  logic                                        is_last;
  logic                                        advance;
  logic [TileW-1:0]                            sel_tile;
  logic [3:0][1:0]                             ao_all [vfc_pkg::NUM_FACES];

  always_comb begin
    sel_face = vfc_pkg::FACE_PX;
    sel_onehot = '0;
    found = 1'b0;
    for (int f = 0; f < vfc_pkg::NUM_FACES; f++) begin
      if (!found && cur_ctl_r.vis[f]) begin
        found = 1'b1;
        sel_face = vfc_pkg::face_t'(3'(f));
        sel_onehot[f] = 1'b1;
      end
    end
  end

  // corners in order bottom-left, bottom-right, top-right, top-left
  always_comb begin
    for (int f = 0; f < vfc_pkg::NUM_FACES; f++) begin
      ao_all[f][0] = vfc_pkg::corner_level(cur_ctl_r.occ, f, -1, -1);
      ao_all[f][1] = vfc_pkg::corner_level(cur_ctl_r.occ, f, 1, -1);
      ao_all[f][2] = vfc_pkg::corner_level(cur_ctl_r.occ, f, 1, 1);
      ao_all[f][3] = vfc_pkg::corner_level(cur_ctl_r.occ, f, -1, 1);
    end
  end

  always_comb begin
    case (sel_face)
      vfc_pkg::FACE_PY: sel_tile = cur_tiles_r[vfc_pkg::SEL_TOP];
      vfc_pkg::FACE_NY: sel_tile = cur_tiles_r[vfc_pkg::SEL_BOTTOM];
      default:          sel_tile = cur_tiles_r[vfc_pkg::SEL_SIDE];
    endcase
  end

  assign cur_vis_nxt = cur_ctl_r.vis & ~sel_onehot;
  assign is_last = (cur_vis_nxt == '0);
  assign advance = cur_valid_r && (!out_valid_r || out_ch.ready);
  assign q_rd_ready = !cur_valid_r || (advance && is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_rd_ready) begin
        cur_valid_r <= q_rd_valid;
        cur_ctl_r   <= q_rd_ctl;
        cur_tiles_r <= q_rd_tiles;
      end else if (advance) begin
        cur_ctl_r.vis <= cur_vis_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        out_face_r  <= sel_face;
        out_tile_r  <= sel_tile;
        out_ao_r    <= ao_all[sel_face];
        out_water_r <= cur_ctl_r.is_water;
        out_last_r  <= is_last;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.face            = out_face_r;
  assign out_ch.tile            = out_tile_r;
  assign out_ch.ao_bottom_left  = out_ao_r[0];
  assign out_ch.ao_bottom_right = out_ao_r[1];
  assign out_ch.ao_top_right    = out_ao_r[2];
  assign out_ch.ao_top_left     = out_ao_r[3];
  assign out_ch.is_water        = out_water_r;
  assign out_ch.last            = out_last_r;

endmodule

// ===== hdl/voxel_face_cull_ao.sv =====
// Visible-face extraction with corner occlusion, one voxel per input transfer.
// in_ch (valid/ready) takes a voxel: kind, 3x3x3 solid and water occupancy,
// texture tiles. out_ch (valid/ready) gives one transfer per visible face in
// order +X,-X,+Y,-Y,+Z,-Z with resolved tile, four corner occlusion levels,
// the water flag and last set on the final face of the voxel.
// A voxel with no visible face (empty kind or fully culled) yields nothing
// and is taken without entering the queue.
// An input transfer is written into the queue, read from there into the back
// end's current-voxel register, and then into the output register on out_ch.
// Throughput: the back end issues one face per cycle unless out_ch stalls, so
// a voxel with n visible faces (up to six) holds it until the last one is out.
// A two-entry queue between classification and emission lets a new voxel be taken
// while faces of earlier ones are still going out; in_ch.ready drops only when it is full.
// Receiver stall: the output register holds its face and the back end and
// queue fill; nothing is lost.
// Reset (rst_n low, synchronous): queue emptied, no face pending, out_ch.valid
// low from the next cycle.
`include "voxel_face_cull_ao_defines.svh"

module voxel_face_cull_ao #(
  parameter int TILE_INDEX_BITS = vfc_pkg::TILE_INDEX_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  vfc_in_if.sink     in_ch,
  vfc_out_if.source  out_ch
);
  localparam int TileW = TILE_INDEX_BITS + 1;
  localparam int TilesW = vfc_pkg::NUM_TILE_SEL * TileW;
  localparam int QueueW = $bits(vfc_pkg::vfc_ctl_t) + TilesW;

  logic                                        q_wr_valid;
  logic                                        q_wr_ready;
  vfc_pkg::vfc_ctl_t                           q_wr_ctl;
  logic [vfc_pkg::NUM_TILE_SEL-1:0][TileW-1:0] q_wr_tiles;
  logic                                        q_rd_valid;
  logic                                        q_rd_ready;
  logic [QueueW-1:0]                           q_rd_data;
  vfc_pkg::vfc_ctl_t                           q_rd_ctl;
  logic [vfc_pkg::NUM_TILE_SEL-1:0][TileW-1:0] q_rd_tiles;
  logic                                        in_idle_xfer;
  logic                                        out_mid_xfer;
  logic                                        out_tile_neg;

  vfc_front #(.TILE_INDEX_BITS(TILE_INDEX_BITS)) u_front (
    .in_ch      (in_ch),
    .q_wr_valid (q_wr_valid),
    .q_wr_ready (q_wr_ready),
    .q_wr_ctl   (q_wr_ctl),
    .q_wr_tiles (q_wr_tiles)
  );

  vfc_queue #(.WIDTH(QueueW)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  ({q_wr_ctl, q_wr_tiles}),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rd_data)
  );

  assign q_rd_ctl   = q_rd_data[QueueW-1:TilesW];
  assign q_rd_tiles = q_rd_data[TilesW-1:0];

  vfc_back #(.TILE_INDEX_BITS(TILE_INDEX_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rd_valid (q_rd_valid),
    .q_rd_ready (q_rd_ready),
    .q_rd_ctl   (q_rd_ctl),
    .q_rd_tiles (q_rd_tiles),
    .out_ch     (out_ch)
  );

  assign in_idle_xfer = in_ch.valid && in_ch.ready &&
                        in_ch.voxel_kind != vfc_pkg::KIND_SOLID &&
                        in_ch.voxel_kind != vfc_pkg::KIND_WATER;
  assign out_mid_xfer = out_ch.valid && out_ch.ready && !out_ch.last;
  assign out_tile_neg = out_ch.valid && out_ch.tile[TileW-1];

  `VFC_ASSERT_NOW(a_empty_kind_dropped, clk, rst_n, in_idle_xfer, !q_wr_valid, "empty voxel queued")
  `VFC_ASSERT_NEXT(a_more_faces_follow, clk, rst_n, out_mid_xfer, out_ch.valid, "gap between faces")
  `VFC_ASSERT_NOW(a_none_tile_is_minus_one, clk, rst_n, out_tile_neg, &out_ch.tile, "bad negative tile")

endmodule

// ===== tb/tb.sv =====
module tb;

  localparam int TILE_W = vfc_pkg::TILE_INDEX_BITS_DEF + 1;
  localparam int NBR_W = vfc_pkg::NBR_BITS;
  localparam int RAND_VOXELS = 320;
  localparam int TAIL_ITEMS = 40;
  localparam int HOLD_CYCLES = 250;
  localparam int HOLD_AFTER_FACES = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]              kind;
    logic [NBR_W-1:0]        solid;
    logic [NBR_W-1:0]        water;
    logic                    textured;
    logic signed [TILE_W-1:0] t_all;
    logic signed [TILE_W-1:0] t_side;
    logic signed [TILE_W-1:0] t_top;
    logic signed [TILE_W-1:0] t_bot;
  } voxel_t;

  typedef struct {
    vfc_pkg::face_t           face;
    logic signed [TILE_W-1:0] tile;
    logic [1:0]               ao_bl;
    logic [1:0]               ao_br;
    logic [1:0]               ao_tr;
    logic [1:0]               ao_tl;
    logic                     water;
    logic                     last;
  } face_rec_t;

  typedef struct packed {
    int x;
    int y;
    int z;
  } step_t;

  logic clk;
  logic rst_n;

  vfc_in_if  in_ch ();
  vfc_out_if out_ch ();

  voxel_face_cull_ao i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  voxel_t    voxel_backlog [$];
  face_rec_t face_q [$];
  voxel_t    cur_voxel;

  int  err_cnt = 0;
  int  total_voxels = 0;
  int  voxels_taken = 0;
  int  solid_voxels = 0;
  int  water_voxels = 0;
  int  empty_voxels = 0;
  int  faces_checked = 0;
  int  in_stall_cycles = 0;
  int  src_gap = 0;
  int  sink_gap = 0;
  int  src_cycle = 0;
  int  sink_cycle = 0;
  bit  src_idle_ok = 1'b1;
  bit  sink_idle_ok = 1'b1;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  logic hold_active;
  logic tail_phase = 1'b0;
  int  quiet_cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic step_t normal_of(input int f);
    case (f)
      0: return '{1, 0, 0};
      1: return '{-1, 0, 0};
      2: return '{0, 1, 0};
      3: return '{0, -1, 0};
      4: return '{0, 0, 1};
      default: return '{0, 0, -1};
    endcase
  endfunction

  function automatic step_t u_axis(input int f);
    case (f)
      0: return '{0, 0, 1};
      1: return '{0, 0, -1};
      2: return '{-1, 0, 0};
      3: return '{-1, 0, 0};
      4: return '{1, 0, 0};
      default: return '{-1, 0, 0};
    endcase
  endfunction

  function automatic step_t v_axis(input int f);
    case (f)
      2: return '{0, 0, -1};
      3: return '{0, 0, 1};
      default: return '{0, 1, 0};
    endcase
  endfunction

  function automatic int cell_index(input int dx, input int dy, input int dz);
    return (dx + 1) * 9 + (dy + 1) * 3 + (dz + 1);
  endfunction

  function automatic bit cell_set(input logic [NBR_W-1:0] m, input int dx, input int dy,
                                  input int dz);
    int b;
    b = cell_index(dx, dy, dz);
    if (b < 0 || b > NBR_W - 1) begin
      return 1'b0;
    end
    return m[b];
  endfunction

  function automatic logic [1:0] corner_ao(input logic [NBR_W-1:0] m, input int f,
                                           input int sx, input int sy);
    step_t a;
    step_t b;
    bit    s1;
    bit    s2;
    bit    c;
    a  = u_axis(f);
    b  = v_axis(f);
    s1 = cell_set(m, a.x * sx, a.y * sx, a.z * sx);
    s2 = cell_set(m, b.x * sy, b.y * sy, b.z * sy);
    c  = cell_set(m, a.x * sx + b.x * sy, a.y * sx + b.y * sy, a.z * sx + b.z * sy);
    if (s1 && s2) begin
      return 2'd3;
    end
    return {1'b0, s1} + {1'b0, s2} + {1'b0, c};
  endfunction

  task automatic predict_faces(input voxel_t v);
    logic [NBR_W-1:0]         occ;
    logic signed [TILE_W-1:0] spec;
    face_rec_t                r;
    step_t                    n;
    int                       first_idx;
    if (v.kind == vfc_pkg::KIND_SOLID) begin
      occ = v.solid;
      solid_voxels++;
    end else if (v.kind == vfc_pkg::KIND_WATER) begin
      occ = v.solid | v.water;
      water_voxels++;
    end else begin
      empty_voxels++;
      return;
    end
    first_idx = face_q.size();
    for (int f = 0; f < vfc_pkg::NUM_FACES; f++) begin
      n = normal_of(f);
      if (!cell_set(occ, n.x, n.y, n.z)) begin
        if (vfc_pkg::face_t'(f) == vfc_pkg::FACE_PY) begin
          spec = v.t_top;
        end else if (vfc_pkg::face_t'(f) == vfc_pkg::FACE_NY) begin
          spec = v.t_bot;
        end else begin
          spec = v.t_side;
        end
        r.face = vfc_pkg::face_t'(f);
        if (!v.textured) begin
          r.tile = '1;
        end else if (!spec[TILE_W-1]) begin
          r.tile = spec;
        end else if (!v.t_all[TILE_W-1]) begin
          r.tile = v.t_all;
        end else begin
          r.tile = '1;
        end
        r.ao_bl = corner_ao(occ, f, -1, -1);
        r.ao_br = corner_ao(occ, f, 1, -1);
        r.ao_tr = corner_ao(occ, f, 1, 1);
        r.ao_tl = corner_ao(occ, f, -1, 1);
        r.water = (v.kind == vfc_pkg::KIND_WATER);
        r.last  = 1'b0;
        face_q.insert(face_q.size(), r);
      end
    end
    if (face_q.size() > first_idx) begin
      face_q[face_q.size() - 1].last = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input int want, input int seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      err_cnt++;
    end
  endtask

  function automatic voxel_t mk_voxel(input logic [1:0] kind, input logic [NBR_W-1:0] solid,
                                      input logic [NBR_W-1:0] water, input logic textured,
                                      input int t_all, input int t_side,
                                      input int t_top, input int t_bot);
    voxel_t v;
    v.kind     = kind;
    v.solid    = solid;
    v.water    = water;
    v.textured = textured;
    v.t_all    = TILE_W'(t_all);
    v.t_side   = TILE_W'(t_side);
    v.t_top    = TILE_W'(t_top);
    v.t_bot    = TILE_W'(t_bot);
    return v;
  endfunction

  task automatic queue_voxel(input voxel_t v);
    voxel_backlog.insert(voxel_backlog.size(), v);
  endtask

  function automatic logic [NBR_W-1:0] rand_mask();
    case ($urandom_range(0, 5))
      0: return NBR_W'($urandom & $urandom & $urandom);
      1: return NBR_W'($urandom & $urandom);
      2: return NBR_W'($urandom);
      3: return NBR_W'($urandom | $urandom);
      4: return '0;
      default: return NBR_W'($urandom & $urandom & $urandom & $urandom);
    endcase
  endfunction

  function automatic logic signed [TILE_W-1:0] rand_tile();
    case ($urandom_range(0, 9))
      0, 1: return '1;
      2: return TILE_W'($urandom_range(0, (1 << TILE_W) - 1));
      3: return TILE_W'((1 << vfc_pkg::TILE_INDEX_BITS_DEF) - 1);
      4: return '0;
      default: return TILE_W'($urandom_range(0, (1 << vfc_pkg::TILE_INDEX_BITS_DEF) - 1));
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid           <= 1'b0;
      in_ch.voxel_kind      <= '0;
      in_ch.solid_neighbors <= '0;
      in_ch.water_neighbors <= '0;
      in_ch.textured        <= 1'b0;
      in_ch.tile_all        <= '0;
      in_ch.tile_side       <= '0;
      in_ch.tile_top        <= '0;
      in_ch.tile_bottom     <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_faces(cur_voxel);
        voxels_taken++;
      end else if (in_ch.valid) begin
        in_stall_cycles++;
      end
      src_cycle++;
      if (src_cycle % 64 == 0) begin
        src_idle_ok = ($urandom_range(0, 3) != 0);
      end
      tail_phase <= (voxel_backlog.size() < TAIL_ITEMS);
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (voxel_backlog.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (src_idle_ok && !tail_phase && !hold_active &&
                     $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(1, 14) - 1;
          in_ch.valid <= 1'b0;
        end else begin
          cur_voxel = voxel_backlog.pop_front();
          in_ch.voxel_kind      <= cur_voxel.kind;
          in_ch.solid_neighbors <= cur_voxel.solid;
          in_ch.water_neighbors <= cur_voxel.water;
          in_ch.textured        <= cur_voxel.textured;
          in_ch.tile_all        <= cur_voxel.t_all;
          in_ch.tile_side       <= cur_voxel.t_side;
          in_ch.tile_top        <= cur_voxel.t_top;
          in_ch.tile_bottom     <= cur_voxel.t_bot;
          in_ch.valid           <= 1'b1;
        end
      end
    end
  end

  // long receiver hold-off so the block fills and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && faces_checked >= HOLD_AFTER_FACES) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end
  end

  assign hold_active = (hold_left > 0);

  // monitor
  always @(posedge clk) begin
    face_rec_t want;
    bit        rdy;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (face_q.size() == 0) begin
          $error("face %0d transferred with no pending expectation", out_ch.face);
          err_cnt++;
        end else begin
          want = face_q.pop_front();
          check_field("face", want.face, out_ch.face);
          check_field("tile", int'(want.tile), int'(out_ch.tile));
          check_field("ao_bottom_left", want.ao_bl, out_ch.ao_bottom_left);
          check_field("ao_bottom_right", want.ao_br, out_ch.ao_bottom_right);
          check_field("ao_top_right", want.ao_tr, out_ch.ao_top_right);
          check_field("ao_top_left", want.ao_tl, out_ch.ao_top_left);
          check_field("is_water", want.water, out_ch.is_water);
          check_field("last", want.last, out_ch.last);
        end
        faces_checked++;
      end
      sink_cycle++;
      if (sink_cycle % 64 == 0) begin
        sink_idle_ok = ($urandom_range(0, 3) != 0);
      end
      if (hold_active) begin
        rdy = 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        rdy = 1'b0;
      end else if (sink_idle_ok && !tail_phase && $urandom_range(0, 5) == 0) begin
        sink_gap = $urandom_range(1, 14) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ch.ready <= rdy;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: %0d faces still expected", face_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    voxel_t           v;
    logic [NBR_W-1:0] ring;
    step_t            n;
    int               formed;

    rst_n = 1'b0;

    // every neighbor set except the six across the faces
    ring = '1;
    for (int f = 0; f < vfc_pkg::NUM_FACES; f++) begin
      n = normal_of(f);
      ring[cell_index(n.x, n.y, n.z)] = 1'b0;
    end

    queue_voxel(mk_voxel(vfc_pkg::KIND_NONE, '1, '1, 1'b1, 5, 6, 7, 8));
    queue_voxel(mk_voxel(KIND_UNUSED, '0, '0, 1'b1, 5, 6, 7, 8));
    queue_voxel(mk_voxel(vfc_pkg::KIND_SOLID, '0, '0, 1'b1, 100, 200, 300, 400));
    queue_voxel(mk_voxel(vfc_pkg::KIND_SOLID, '1, '0, 1'b1, 1, 2, 3, 4));
    queue_voxel(mk_voxel(vfc_pkg::KIND_WATER, '0, '1, 1'b1, 1, 2, 3, 4));
    queue_voxel(mk_voxel(vfc_pkg::KIND_WATER, '1, '0, 1'b1, 1, 2, 3, 4));
    queue_voxel(mk_voxel(vfc_pkg::KIND_SOLID, '0, '1, 1'b1, 4095, -1, -1, -1));
    queue_voxel(mk_voxel(vfc_pkg::KIND_WATER, '0, '0, 1'b1, -1, -1, -1, -1));
    queue_voxel(mk_voxel(vfc_pkg::KIND_SOLID, '0, '0, 1'b1, 9, -4096, -2, -100));
    queue_voxel(mk_voxel(vfc_pkg::KIND_SOLID, '0, '0, 1'b1, -4096, -2, -3, -5));
    queue_voxel(mk_voxel(vfc_pkg::KIND_SOLID, '0, '0, 1'b0, 1, 2, 3, 4));
    queue_voxel(mk_voxel(vfc_pkg::KIND_SOLID, NBR_W'(1) << 13, NBR_W'(1) << 13,
                         1'b1, 0, 0, 0, 0));
    queue_voxel(mk_voxel(vfc_pkg::KIND_SOLID, ring, '0, 1'b1, 4095, 4095, 4095, 4095));
    queue_voxel(mk_voxel(vfc_pkg::KIND_WATER, '0, ring, 1'b1, 0, -1, 4095, -1));
    queue_voxel(mk_voxel(vfc_pkg::KIND_WATER, ring & 27'h5555555, ring & 27'h2AAAAAA,
                         1'b1, 17, -1, 33, 44));
    queue_voxel(mk_voxel(vfc_pkg::KIND_SOLID, 27'h5555555, '0, 1'b1, 1, 2, 3, 4));
    queue_voxel(mk_voxel(vfc_pkg::KIND_SOLID, 27'h2AAAAAA, 27'h5555555, 1'b1,
                         -1, 2, -1, 4));
    for (int f = 0; f < vfc_pkg::NUM_FACES; f++) begin
      n = normal_of(f);
      queue_voxel(mk_voxel((f % 2 == 0) ? vfc_pkg::KIND_SOLID : vfc_pkg::KIND_WATER,
                           NBR_W'(1) << cell_index(n.x, n.y, n.z), '0,
                           1'b1, 10 + f, 20 + f, 30 + f, 40 + f));
    end

    formed = 0;
    while (formed < RAND_VOXELS) begin
      if ($urandom_range(0, 9) == 0) begin
        v.kind = 2'($urandom_range(0, 3));
      end else begin
        v.kind = $urandom_range(0, 1) ? vfc_pkg::KIND_SOLID : vfc_pkg::KIND_WATER;
      end
      v.solid    = rand_mask();
      v.water    = rand_mask();
      v.textured = ($urandom_range(0, 4) != 0);
      v.t_all    = rand_tile();
      v.t_side   = rand_tile();
      v.t_top    = rand_tile();
      v.t_bot    = rand_tile();
      queue_voxel(v);
      if (v.kind == vfc_pkg::KIND_SOLID || v.kind == vfc_pkg::KIND_WATER) begin
        formed++;
      end
    end
    total_voxels = voxel_backlog.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (voxels_taken < total_voxels) @(posedge clk);
    while (face_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d voxels sent (%0d solid, %0d water, %0d empty or unused), %0d faces checked",
             voxels_taken, solid_voxels, water_voxels, empty_voxels, faces_checked);
    $display("receiver held off %0d cycles once; input stalled on ready for %0d cycles",
             HOLD_CYCLES, in_stall_cycles);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/vfc_pkg.sv
hdl/vfc_if.sv
hdl/vfc_front.sv
hdl/vfc_queue.sv
hdl/vfc_back.sv
hdl/voxel_face_cull_ao.sv
tb/tb.sv
